[src/ose_pkg.sv]
package ose_pkg;

    localparam int ALPHA_W     = 8;
    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 1;
    localparam int LEFT_W      = 12;
    localparam int RIGHT_W     = 13;
    localparam int ROW_W       = 12;
    localparam int MAX_DIM_DEF = 4096;

    localparam logic [ALPHA_W-1:0] BG_ALPHA = 8'hFF;

    localparam logic [CFG_W-1:0] WIDTH_RST  = 13'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 13'd480;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    typedef struct packed {
        logic [LEFT_W-1:0]  span_left;
        logic [RIGHT_W-1:0] span_right;
        logic [ROW_W-1:0]   span_row;
    } t_span;

endpackage

[src/ose_pixel_if.sv]
interface ose_pixel_if;
    logic                         valid;
    logic                         ready;
    logic [ose_pkg::ALPHA_W-1:0]  pixel_alpha;

    modport source (output valid, output pixel_alpha, input ready);
    modport sink   (input valid, input pixel_alpha, output ready);
endinterface

[src/ose_span_if.sv]
interface ose_span_if;
    logic                         valid;
    logic                         ready;
    logic [ose_pkg::LEFT_W-1:0]   span_left;
    logic [ose_pkg::RIGHT_W-1:0]  span_right;
    logic [ose_pkg::ROW_W-1:0]    span_row;

    modport source (output valid, output span_left, output span_right, output span_row,
                    input ready);
    modport sink   (input valid, input span_left, input span_right, input span_row,
                    output ready);
endinterface

[src/ose_run_tracker.sv]
module ose_run_tracker #(
    parameter int MAX_DIM = ose_pkg::MAX_DIM_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic [ose_pkg::ALPHA_W-1:0] i_alpha,
    input  logic [ose_pkg::CFG_W-1:0]   i_width,
    input  logic [ose_pkg::CFG_W-1:0]   i_height,
    output logic                        o_emit,
    output ose_pkg::t_span              o_span
);

    localparam int CW = $clog2(MAX_DIM);
    localparam int XW = (CW + 1 > ose_pkg::CFG_W) ? CW + 1 : ose_pkg::CFG_W;

    logic [CW-1:0] r_col, n_col;
    logic [CW-1:0] r_row, n_row;
    logic          r_open, n_open;
    logic [CW-1:0] r_start, n_start;

    logic [XW-1:0] w_eff, h_eff, w_ext, h_ext;
    logic [XW-1:0] col_inc, row_inc, right;
    logic          bg, last_col;

    always_comb begin
        w_ext = XW'(i_width);
        h_ext = XW'(i_height);
        if (w_ext == '0) begin
            w_eff = XW'(1);
        end else if (w_ext > XW'(MAX_DIM)) begin
            w_eff = XW'(MAX_DIM);
        end else begin
            w_eff = w_ext;
        end
        if (h_ext == '0) begin
            h_eff = XW'(1);
        end else if (h_ext > XW'(MAX_DIM)) begin
            h_eff = XW'(MAX_DIM);
        end else begin
            h_eff = h_ext;
        end
    end

    always_comb begin
        bg       = (i_alpha == ose_pkg::BG_ALPHA);
        col_inc  = XW'(r_col) + XW'(1);
        row_inc  = XW'(r_row) + XW'(1);
        last_col = (col_inc >= w_eff);
        n_open   = r_open;
        n_start  = r_start;
        o_emit   = 1'b0;
        right    = XW'(r_col);

        if (r_open) begin
            if (bg) begin
                o_emit = 1'b1;
                n_open = 1'b0;
            end
        end else if (!bg) begin
            n_start = r_col;
            n_open  = 1'b1;
        end

        if (last_col) begin
            if (n_open) begin
                o_emit = 1'b1;
                right  = col_inc;
                n_open = 1'b0;
            end
            n_col = '0;
            n_row = (row_inc >= h_eff) ? '0 : CW'(row_inc);
        end else begin
            n_col = CW'(col_inc);
            n_row = r_row;
        end

        o_span.span_left  = ose_pkg::LEFT_W'(n_start);
        o_span.span_right = ose_pkg::RIGHT_W'(right);
        o_span.span_row   = ose_pkg::ROW_W'(r_row);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_open  <= 1'b0;
            r_start <= '0;
        end else if (i_step) begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_open  <= n_open;
            r_start <= n_start;
        end
    end

endmodule

[src/opaque_span_extractor.sv]
// Opaque span extractor: turns a raster stream of alpha bytes into runs of
// shown (non-background) pixels, one request per scan-line run.
// Input channel i_pix carries one pixel_alpha per request in raster order;
// 0xFF is background, any other value is shown.
// Output channel o_span carries span_left, exclusive span_right and span_row
// of each closed run. A run closes at the next background pixel or at the
// last column of the row.
// Configuration: i_cfg_we writes i_cfg_data into image_width (index 0) or
// image_height (index 1); write only while the block is idle.
// A run appears on o_span in the cycle after the pixel that closes it is accepted.
// Throughput: one pixel per cycle while o_span is not stalled, set by the single output register.
// A stalled o_span holds the pending span; i_pix stays ready as long as the
// output register is empty or being emptied in the same cycle.
// Reset clears the column, row and open-run state, drops any pending span
// and restores width 640 and height 480.
module opaque_span_extractor #(
    parameter int MAX_DIM = ose_pkg::MAX_DIM_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ose_pixel_if.sink                     i_pix,
    ose_span_if.source                    o_span,
    input  logic                          i_cfg_we,
    input  logic [ose_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ose_pkg::CFG_W-1:0]     i_cfg_data
);

    logic [ose_pkg::CFG_W-1:0] r_width, r_height;
    logic                      r_out_valid;
    ose_pkg::t_span            r_span;

    logic                      accept, emit;
    ose_pkg::t_span            span;

    assign i_pix.ready = !r_out_valid || o_span.ready;
    assign accept      = i_pix.valid && i_pix.ready;

    ose_run_tracker #(
        .MAX_DIM (MAX_DIM)
    ) u_tracker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (accept),
        .i_alpha  (i_pix.pixel_alpha),
        .i_width  (r_width),
        .i_height (r_height),
        .o_emit   (emit),
        .o_span   (span)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= ose_pkg::WIDTH_RST;
            r_height <= ose_pkg::HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ose_pkg::REG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                ose_pkg::REG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= emit;
        end else if (o_span.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_span <= span;
        end
    end

    assign o_span.valid      = r_out_valid;
    assign o_span.span_left  = r_span.span_left;
    assign o_span.span_right = r_span.span_right;
    assign o_span.span_row   = r_span.span_row;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_span.valid)
        else $error("span pending after reset");

    a_emit_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && emit |=> o_span.valid)
        else $error("closed run not presented");

    a_no_repeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_span.valid && o_span.ready && !(accept && emit) |=> !o_span.valid)
        else $error("span repeated after transfer");

endmodule

[verif/opaque_span_extractor_tb.sv]
`timescale 1ns / 100ps

module opaque_span_extractor_tb;

    localparam int IDLE_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;

    class run_tracker;
        logic [ose_pkg::CFG_W-1:0] width_reg;
        logic [ose_pkg::CFG_W-1:0] height_reg;
        logic [ose_pkg::LEFT_W-1:0] col_pos;
        logic [ose_pkg::ROW_W-1:0] row_pos;
        logic [ose_pkg::LEFT_W-1:0] run_first;
        bit run_live;
        ose_pkg::t_span due_spans[$];
        int errors;

        function new();
            width_reg = ose_pkg::WIDTH_RST;
            height_reg = ose_pkg::HEIGHT_RST;
            col_pos = '0;
            row_pos = '0;
            run_first = '0;
            run_live = 1'b0;
            errors = 0;
        endfunction

        function int unsigned eff_dim(logic [ose_pkg::CFG_W-1:0] v);
            if (v == 0) begin
                return 1;
            end
            if (v > ose_pkg::MAX_DIM_DEF) begin
                return ose_pkg::MAX_DIM_DEF;
            end
            return v;
        endfunction

        function void write_reg(logic [ose_pkg::CFG_IDX_W-1:0] idx,
                                logic [ose_pkg::CFG_W-1:0] val);
            case (idx)
                ose_pkg::REG_IMAGE_WIDTH: begin
                    width_reg = val;
                end
                ose_pkg::REG_IMAGE_HEIGHT: begin
                    height_reg = val;
                end
                default: ;
            endcase
        endfunction

        function void take_pixel(logic [ose_pkg::ALPHA_W-1:0] alpha);
            int unsigned w;
            int unsigned h;
            bit bg;
            bit row_end;
            ose_pkg::t_span s;
            w = eff_dim(width_reg);
            h = eff_dim(height_reg);
            bg = (alpha == ose_pkg::BG_ALPHA);
            row_end = (int'(col_pos) + 1) >= w;
            if (run_live) begin
                if (bg) begin
                    s.span_left = run_first;
                    s.span_right = ose_pkg::RIGHT_W'(col_pos);
                    s.span_row = row_pos;
                    due_spans.push_back(s);
                    run_live = 1'b0;
                end
            end else if (!bg) begin
                run_first = col_pos;
                run_live = 1'b1;
            end
            if (row_end) begin
                if (run_live) begin
                    s.span_left = run_first;
                    s.span_right = ose_pkg::RIGHT_W'(col_pos) + 1'b1;
                    s.span_row = row_pos;
                    due_spans.push_back(s);
                    run_live = 1'b0;
                end
                col_pos = '0;
                if ((int'(row_pos) + 1) >= h) begin
                    row_pos = '0;
                end else begin
                    row_pos = row_pos + 1'b1;
                end
            end else begin
                col_pos = col_pos + 1'b1;
            end
        endfunction

        function void check_span(ose_pkg::t_span got);
            ose_pkg::t_span want;
            if (due_spans.size() == 0) begin
                $error("unexpected span: left %0d right %0d row %0d",
                       got.span_left, got.span_right, got.span_row);
                errors++;
                return;
            end
            want = due_spans.pop_front();
            if (got.span_left !== want.span_left) begin
                $error("span_left: expected %0d, got %0d", want.span_left, got.span_left);
                errors++;
            end
            if (got.span_right !== want.span_right) begin
                $error("span_right: expected %0d, got %0d", want.span_right, got.span_right);
                errors++;
            end
            if (got.span_row !== want.span_row) begin
                $error("span_row: expected %0d, got %0d", want.span_row, got.span_row);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [ose_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [ose_pkg::CFG_W-1:0] i_cfg_data;

    ose_pixel_if pix_ch ();
    ose_span_if span_ch ();

    opaque_span_extractor dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_pix(pix_ch),
        .o_span(span_ch),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    run_tracker runs;
    bit hold_req;
    bit valid_high;
    int burst_left;
    int idle_cycles;

    logic [ose_pkg::ALPHA_W-1:0] dir_first [9] = '{8'h00, 8'h7F, ose_pkg::BG_ALPHA, 8'hFE,
                                                   8'h80, 8'h01, ose_pkg::BG_ALPHA,
                                                   ose_pkg::BG_ALPHA, 8'h55};
    logic [ose_pkg::ALPHA_W-1:0] dir_rows [16] = '{8'hAA,
                                                   ose_pkg::BG_ALPHA, 8'h00, 8'h11,
                                                   ose_pkg::BG_ALPHA, 8'h22,
                                                   8'h33, 8'h44, 8'h55, 8'h66,
                                                   ose_pkg::BG_ALPHA, ose_pkg::BG_ALPHA,
                                                   ose_pkg::BG_ALPHA, ose_pkg::BG_ALPHA,
                                                   ose_pkg::BG_ALPHA, 8'h01};

    initial begin
        i_clk = 1'b0;
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    function automatic logic [ose_pkg::ALPHA_W-1:0] pick_alpha();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            return ose_pkg::BG_ALPHA;
        end
        if (r < 45) begin
            return 8'hFE;
        end
        if (r < 50) begin
            return 8'h00;
        end
        return ose_pkg::ALPHA_W'($urandom_range(0, 254));
    endfunction

    function automatic logic [ose_pkg::CFG_W-1:0] pick_dim(int unsigned top);
        int r;
        r = $urandom_range(0, 11);
        case (r)
            0: begin
                return '0;
            end
            1: begin
                return 13'd1;
            end
            2: begin
                return '1;
            end
            default: begin
                return ose_pkg::CFG_W'($urandom_range(1, top));
            end
        endcase
    endfunction

    task automatic push_pixel(input logic [ose_pkg::ALPHA_W-1:0] alpha);
        int gap;
        pix_ch.valid <= 1'b1;
        pix_ch.pixel_alpha <= alpha;
        valid_high = 1'b1;
        do @(posedge i_clk); while (pix_ch.ready !== 1'b1);
        runs.take_pixel(alpha);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                pix_ch.valid <= 1'b0;
                valid_high = 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
    endtask

    task automatic end_burst();
        if (valid_high) begin
            pix_ch.valid <= 1'b0;
            valid_high = 1'b0;
        end
    endtask

    task automatic drain_spans();
        end_burst();
        while (runs.due_spans.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_frame(input bit do_w, input logic [ose_pkg::CFG_W-1:0] w,
                             input bit do_h, input logic [ose_pkg::CFG_W-1:0] h);
        drain_spans();
        if (do_w) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= ose_pkg::REG_IMAGE_WIDTH;
            i_cfg_data <= w;
            @(posedge i_clk);
            runs.write_reg(ose_pkg::REG_IMAGE_WIDTH, w);
        end
        if (do_h) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= ose_pkg::REG_IMAGE_HEIGHT;
            i_cfg_data <= h;
            @(posedge i_clk);
            runs.write_reg(ose_pkg::REG_IMAGE_HEIGHT, h);
        end
        i_cfg_we <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        ose_pkg::t_span got;
        if (i_rst_n === 1'b1 && span_ch.valid === 1'b1 && span_ch.ready === 1'b1) begin
            got.span_left = span_ch.span_left;
            got.span_right = span_ch.span_right;
            got.span_row = span_ch.span_row;
            runs.check_span(got);
        end
    end

    initial begin
        int mode;
        int len;
        span_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_req) begin
                span_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                mode = $urandom_range(0, 3);
                len = $urandom_range(1, 40);
                repeat (len) begin
                    case (mode)
                        0: span_ch.ready <= 1'b1;
                        1: span_ch.ready <= 1'($urandom_range(0, 1));
                        2: span_ch.ready <= ($urandom_range(0, 4) == 0);
                        default: span_ch.ready <= ($urandom_range(0, 3) != 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((pix_ch.valid === 1'b1 && pix_ch.ready === 1'b1) ||
                (span_ch.valid === 1'b1 && span_ch.ready === 1'b1)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("[opaque_span_extractor] ERROR");
        $finish;
    end

    initial begin
        int n_items;
        int r;
        runs = new();
        hold_req = 1'b0;
        valid_high = 1'b0;
        burst_left = 0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= ose_pkg::REG_IMAGE_WIDTH;
        i_cfg_data <= '0;
        pix_ch.valid <= 1'b0;
        pix_ch.pixel_alpha <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_first[i]) begin
            push_pixel(dir_first[i]);
        end
        set_frame(1'b1, 13'd5, 1'b1, 13'd3);
        foreach (dir_rows[i]) begin
            push_pixel(dir_rows[i]);
        end

        set_frame(1'b1, 13'd0, 1'b1, 13'd0);
        repeat (6) push_pixel(pick_alpha());

        for (int p = 0; p < 30; p++) begin
            r = $urandom_range(0, 5);
            set_frame(r != 0, pick_dim(24), r != 1, pick_dim(6));
            n_items = 19;
            if (p == 4) begin
                hold_req = 1'b1;
                n_items = 150;
            end
            repeat (n_items) push_pixel(pick_alpha());
        end

        set_frame(1'b1, '1, 1'b1, '1);
        repeat (30) push_pixel(pick_alpha());

        drain_spans();
        repeat (10) @(posedge i_clk);
        if (runs.errors == 0 && runs.due_spans.size() == 0) begin
            $display("[opaque_span_extractor] OK");
        end else begin
            $display("[opaque_span_extractor] ERROR");
        end
        $finish;
    end

endmodule
